>>> rtl/core/hbpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heartbeat publication timer package
// Payload and configuration types, register indexes and the count/period
// decode helpers shared by the core and its step logic.
// ----------------------------------------------------------------------------
package hbpt_pkg;

	// Feature word handling
	localparam int FEATURE_BITS = 4;
	localparam int FEAT_W       = 4;
	localparam logic [31:0] FEAT_MASK_W = (32'd1 << FEATURE_BITS) - 32'd1;
	localparam logic [FEAT_W-1:0] FEAT_MASK = FEAT_MASK_W[FEAT_W-1:0];

	// Field widths
	localparam int ADDR_W    = 16;
	localparam int TTL_W     = 7;
	localparam int PLOG_W    = 5;
	localparam int CLOG_W    = 8;
	localparam int SECS_W    = 16;
	localparam int FWORD_W   = 16;
	localparam int ELAPSED_W = 32;
	localparam int COUNT_W   = 16;
	localparam int PERIOD_W  = 17;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;

	// Special codes
	localparam logic [CLOG_W-1:0]  COUNT_EXP_INDEF = 8'hFF;
	localparam logic [CLOG_W-1:0]  COUNT_EXP_SAT   = 8'h11;
	localparam logic [PLOG_W-1:0]  PERIOD_EXP_MAX  = 5'h11;
	localparam logic [COUNT_W-1:0] COUNT_SAT       = 16'hFFFF;

	typedef enum logic {
		OP_TICK    = 1'b0,
		OP_FEATURE = 1'b1
	} hbpt_op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEST_ADDRESS     = 3'd0,
		REG_PUBLISH_TTL      = 3'd1,
		REG_PERIOD_EXP       = 3'd2,
		REG_COUNT_EXP        = 3'd3,
		REG_TRIGGER_FEATURES = 3'd4
	} hbpt_reg_t;

	typedef struct packed {
		hbpt_op_t             op;
		logic [SECS_W-1:0]    seconds;
		logic [FWORD_W-1:0]   current_features;
		logic [FWORD_W-1:0]   previous_features;
	} hbpt_in_t;

	typedef struct packed {
		logic                 send_heartbeat;
		logic [TTL_W-1:0]     beat_ttl;
		logic [FEAT_W-1:0]    features_out;
		logic [CLOG_W-1:0]    remaining_log;
		logic                 timer_active;
	} hbpt_out_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_DAT_W-1:0] value;
	} hbpt_cfg_wr_t;

	typedef struct packed {
		logic [ADDR_W-1:0]    dest_address;
		logic [TTL_W-1:0]     publish_ttl;
		logic [PLOG_W-1:0]    period_exp;
		logic [CLOG_W-1:0]    count_exp;
		logic [FEAT_W-1:0]    trigger_features;
	} hbpt_cfg_t;

	typedef struct packed {
		logic [ELAPSED_W-1:0] elapsed_seconds;
		logic [COUNT_W-1:0]   remaining_count;
	} hbpt_state_t;

	// Period in seconds; zero when periodic publishing is off.
	function automatic logic [PERIOD_W-1:0] period_secs(input logic [PLOG_W-1:0] plog);
		logic [PERIOD_W-1:0] per;
		per = '0;
		if (plog != '0 && plog <= PERIOD_EXP_MAX) begin
			per = PERIOD_W'(1) << (plog - PLOG_W'(1));
		end
		return per;
	endfunction

	function automatic logic [COUNT_W-1:0] decode_count(input logic [CLOG_W-1:0] clog);
		logic [COUNT_W-1:0] cnt;
		if (clog == '0) begin
			cnt = '0;
		end else if (clog >= COUNT_EXP_SAT) begin
			cnt = COUNT_SAT;
		end else begin
			cnt = COUNT_W'(1) << (clog - CLOG_W'(1));
		end
		return cnt;
	endfunction

	// Smallest n with 2^(n-1) >= cnt, i.e. one plus the bit length of cnt-1; zero and COUNT_SAT give 0 and INDEF.
	function automatic logic [CLOG_W-1:0] encode_count(input logic [COUNT_W-1:0] cnt);
		logic [COUNT_W-1:0] m;
		logic [CLOG_W-1:0]  len;
		logic [CLOG_W-1:0]  res;
		m   = cnt - COUNT_W'(1);
		len = '0;
		for (int i = 0; i < COUNT_W; i++) begin
			if (m[i]) begin
				len = CLOG_W'(i + 1);
			end
		end
		if (cnt == '0) begin
			res = '0;
		end else if (cnt == COUNT_SAT) begin
			res = COUNT_EXP_INDEF;
		end else begin
			res = len + CLOG_W'(1);
		end
		return res;
	endfunction

endpackage

>>> rtl/core/hbpt_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heartbeat publication timer stream interface
// Valid/ready channel carrying one word of type T per handshake.
// ----------------------------------------------------------------------------
interface hbpt_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/heartbeat_publication_timer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heartbeat publication timer
// Periodic and feature-triggered heartbeat scheduler with register port.
// ----------------------------------------------------------------------------
// The block takes one word per clock on the item channel while the result
// channel does not stall, and returns exactly one result word for each, in
// order. A word passes an input register and then the result register
// before its result is offered on the result channel. Throughput is one
// word per cycle under the same condition, set by the single add, compare and
// decrement between the two registers. The result register lets the next
// word enter while a finished result still waits on a stalled result
// channel. A tick word adds its seconds to the elapsed time (modulo 2^32)
// while the timer is active and sends at most one heartbeat, taking one
// period and, unless the count is indefinite, one publication off. A feature
// word sends a heartbeat when a changed feature bit is also a trigger bit and
// the destination is assigned. Any write to a known register index reloads
// the timer: elapsed time becomes one full period, so the first heartbeat is
// due on the next tick, and the remaining count is decoded from the count
// log. Writes to unknown indexes are dropped. The register channel is always
// ready; write it only while no item is in flight.
// ----------------------------------------------------------------------------
module heartbeat_publication_timer (
	input  logic                 clk,
	input  logic                 arst_n,
	hbpt_stream_if.sink          item,
	hbpt_stream_if.source        result,
	hbpt_stream_if.sink          cfg
);
	hbpt_pkg::hbpt_cfg_t   cfg_q;
	hbpt_pkg::hbpt_cfg_t   cfg_d;
	hbpt_pkg::hbpt_state_t state_q;
	hbpt_pkg::hbpt_state_t state_nxt;
	hbpt_pkg::hbpt_state_t state_reload;
	hbpt_pkg::hbpt_in_t    item_s1;
	hbpt_pkg::hbpt_out_t   res;
	hbpt_pkg::hbpt_out_t   res_q;
	hbpt_pkg::hbpt_cfg_wr_t cfg_wr;
	logic                  valid_s1;
	logic                  res_valid_q;
	logic                  advance;
	logic                  item_take;
	logic                  cfg_hit;

	// Register port: always ready, decode index into the shadow of cfg_q.
	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.data;

	always_comb begin
		cfg_d   = cfg_q;
		cfg_hit = 1'b0;
		case (hbpt_pkg::hbpt_reg_t'(cfg_wr.index))
			hbpt_pkg::REG_DEST_ADDRESS: begin
				cfg_d.dest_address = cfg_wr.value[hbpt_pkg::ADDR_W-1:0];
				cfg_hit            = cfg.valid;
			end
			hbpt_pkg::REG_PUBLISH_TTL: begin
				cfg_d.publish_ttl = cfg_wr.value[hbpt_pkg::TTL_W-1:0];
				cfg_hit           = cfg.valid;
			end
			hbpt_pkg::REG_PERIOD_EXP: begin
				cfg_d.period_exp = cfg_wr.value[hbpt_pkg::PLOG_W-1:0];
				cfg_hit          = cfg.valid;
			end
			hbpt_pkg::REG_COUNT_EXP: begin
				cfg_d.count_exp = cfg_wr.value[hbpt_pkg::CLOG_W-1:0];
				cfg_hit         = cfg.valid;
			end
			hbpt_pkg::REG_TRIGGER_FEATURES: begin
				cfg_d.trigger_features = cfg_wr.value[hbpt_pkg::FEAT_W-1:0];
				cfg_hit                = cfg.valid;
			end
			default: begin
				cfg_hit = 1'b0;
			end
		endcase
	end

	// Reload values come from the configuration as it stands after the write.
	always_comb begin
		state_reload.elapsed_seconds =
			hbpt_pkg::ELAPSED_W'(hbpt_pkg::period_secs(cfg_d.period_exp));
		state_reload.remaining_count = (cfg_d.count_exp == hbpt_pkg::COUNT_EXP_INDEF)
			? '0 : hbpt_pkg::decode_count(cfg_d.count_exp);
	end

	// Advance the input stage whenever the result register is free or drains.
	assign advance    = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign item_take  = item.valid && item.ready;

	hbpt_step u_step (
		.cfg_q     (cfg_q),
		.state_q   (state_q),
		.item_s1   (item_s1),
		.state_nxt (state_nxt),
		.res       (res)
	);

	// Control and timer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q       <= '0;
			state_q     <= '0;
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (item_take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end

			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end

			// Writes must land only while idle; the block does not enforce it, and a reload overrides an advance.
			if (cfg_hit) begin
				cfg_q   <= cfg_d;
				state_q <= state_reload;
			end else if (advance) begin
				state_q <= state_nxt;
			end
		end
	end

	// Payload registers: hold until the stage moves.
	always_ff @(posedge clk) begin
		if (item_take) begin
			item_s1 <= item.data;
		end
		if (advance) begin
			res_q <= res;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

`ifndef NO_ASSERTIONS
	// An indefinite count never carries a remaining count.
	a_indef_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_q.count_exp == hbpt_pkg::COUNT_EXP_INDEF) |-> (state_q.remaining_count == '0))
		else $error("remaining count nonzero with indefinite count log");

	// The remaining count only grows through a register reload.
	a_count_no_grow: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_hit |=> (state_q.remaining_count <= $past(state_q.remaining_count)))
		else $error("remaining count grew without a reload");

	// A result without a heartbeat carries no TTL and no features.
	a_quiet_result: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_q.send_heartbeat)
		|-> (res_q.beat_ttl == '0 && res_q.features_out == '0))
		else $error("idle result carries heartbeat payload");

	// A new result appears only after the input stage advanced.
	a_result_from_stage: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(advance))
		else $error("result appeared without an input word");
`endif

endmodule

>>> rtl/core/hbpt_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heartbeat publication timer step
// Next timer state and result word for one input word.
// ----------------------------------------------------------------------------
module hbpt_step (
	input  hbpt_pkg::hbpt_cfg_t   cfg_q,
	input  hbpt_pkg::hbpt_state_t state_q,
	input  hbpt_pkg::hbpt_in_t    item_s1,
	output hbpt_pkg::hbpt_state_t state_nxt,
	output hbpt_pkg::hbpt_out_t   res
);
	logic [hbpt_pkg::ELAPSED_W-1:0] per;
	logic [hbpt_pkg::ELAPSED_W-1:0] sum;
	logic [hbpt_pkg::ELAPSED_W-1:0] diff;
	logic [hbpt_pkg::FEAT_W-1:0]    changed;
	logic                           indef;
	logic                           dest_ok;
	logic                           timer_on;
	logic                           fire;
	logic                           send;

	assign per     = hbpt_pkg::ELAPSED_W'(hbpt_pkg::period_secs(cfg_q.period_exp));
	assign indef   = (cfg_q.count_exp == hbpt_pkg::COUNT_EXP_INDEF);
	assign dest_ok = (cfg_q.dest_address != '0);
	assign timer_on = dest_ok && (per != '0) && (indef || state_q.remaining_count != '0);

	assign sum  = state_q.elapsed_seconds + hbpt_pkg::ELAPSED_W'(item_s1.seconds);
	assign diff = sum - per;
	assign fire = (sum >= per);

	assign changed = (item_s1.previous_features[hbpt_pkg::FEAT_W-1:0]
		^ item_s1.current_features[hbpt_pkg::FEAT_W-1:0]) & hbpt_pkg::FEAT_MASK;

	always_comb begin
		state_nxt = state_q;
		send      = 1'b0;
		case (item_s1.op)
			hbpt_pkg::OP_TICK: begin
				if (timer_on) begin
					state_nxt.elapsed_seconds = fire ? diff : sum;
					if (fire) begin
						send = 1'b1;
						if (!indef && state_q.remaining_count != '0) begin
							state_nxt.remaining_count = state_q.remaining_count
								- hbpt_pkg::COUNT_W'(1);
						end
					end
				end
			end
			hbpt_pkg::OP_FEATURE: begin
				send = dest_ok && ((changed & cfg_q.trigger_features) != '0);
			end
			default: begin
				send = 1'b0;
			end
		endcase
	end

	always_comb begin
		res.send_heartbeat = send;
		res.beat_ttl       = send ? cfg_q.publish_ttl : '0;
		res.features_out   = send ? (item_s1.current_features[hbpt_pkg::FEAT_W-1:0]
			& hbpt_pkg::FEAT_MASK) : '0;
		res.remaining_log  = indef ? hbpt_pkg::COUNT_EXP_INDEF
			: hbpt_pkg::encode_count(state_nxt.remaining_count);
		res.timer_active   = dest_ok && (per != '0)
			&& (indef || state_nxt.remaining_count != '0);
	end

endmodule
